// ----- design/fixed_point_alu_defines.svh -----
// Assertion macros used by the fixed-point ALU top module.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH
`ifndef ASSERT_OFF
`define FPA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define FPA_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FPA_ASSERT(label, clk, rst_n, prop)
`define FPA_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- design/fpa_pkg.sv -----
`timescale 1ns / 1ps
package fpa_pkg;
	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_CMP = 4'd4,
		OP_MIN = 4'd5, OP_MAX = 4'd6, OP_INC = 4'd7, OP_DEC = 4'd8,
		OP_TO_INT = 4'd9, OP_FROM_INT = 4'd10
	} op_kind_t;

	localparam int WORD_W = 32;

	typedef struct packed {
		logic [3:0]         kind;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               less;
		logic               greater;
		logic               equal;
		logic               overflow;
		logic               divide_by_zero;
	} rsp_t;

	// Per-item control that rides alongside the datapath.
	typedef struct packed {
		logic [3:0] kind;
		logic       neg;
		logic       less;
		logic       greater;
		logic       equal;
		logic       a_zero;
		logic       a_neg;
		logic       b_zero;
	} ctl_t;

	localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
endpackage

// ----- design/fixed_point_alu.sv -----
`timescale 1ns / 1ps
// Signed fixed-point ALU on 32-bit raw words with FRAC_BITS fraction bits.
// Requests enter on the req channel (valid/ready, packed struct with kind and
// two operands); each request gives exactly one response on the rsp channel.
// Operations: add, sub, mul, div, compare, min, max, inc, dec, to_int and
// from_int. Multiply and divide round to nearest, halves away from zero.
// Add, sub, mul, div, inc, dec and from_int saturate and flag overflow.
// Every kind passes 35 + FRAC_BITS register stages: two front stages, one
// divider stage per quotient bit (32 + FRAC_BITS), and the output register.
// All kinds share that pipe so order holds. Throughput is one request per
// cycle unless the receiver stalls. The whole pipe advances together when
// the output register is empty or being taken; when the receiver stalls with
// a full output register, the pipe freezes and req_ready drops, so nothing is
// lost or repeated. Reset clears all valid bits; payload needs no reset.
module fixed_point_alu #(
	parameter int FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fpa_pkg::rsp_t rsp
);
	import fpa_pkg::*;

	localparam int NUM_W = 32 + FRAC_BITS;

	logic adv;
	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	// Stage 1: magnitudes, flags and simple operations.
	ctl_t             ctl_s1;
	logic [31:0]      ma_s1, mb_s1;
	logic signed [33:0] simple_s1;
	logic             v_s1;
	logic [32:0]      abs_a, abs_b;
	logic signed [33:0] simple;
	logic signed [32:0] sa, sb;
	always_comb begin
		sa = {req.operand_a[31], req.operand_a};
		sb = {req.operand_b[31], req.operand_b};
		abs_a = req.operand_a[31] ? -sa : sa;
		abs_b = req.operand_b[31] ? -sb : sb;
		case (req.kind)
			OP_ADD:      simple = 34'(sa) + 34'(sb);
			OP_SUB:      simple = 34'(sa) - 34'(sb);
			OP_MIN:      simple = (sa < sb) ? 34'(sa) : 34'(sb);
			OP_MAX:      simple = (sa > sb) ? 34'(sa) : 34'(sb);
			OP_INC:      simple = 34'(sa) + 34'sd1;
			OP_DEC:      simple = 34'(sa) - 34'sd1;
			OP_TO_INT:   simple = 34'(req.operand_a >>> FRAC_BITS);
			default:     simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= req_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.kind    <= req.kind;
			ctl_s1.neg     <= req.operand_a[31] ^ req.operand_b[31];
			ctl_s1.less    <= sa < sb;
			ctl_s1.greater <= sa > sb;
			ctl_s1.equal   <= sa == sb;
			ctl_s1.a_zero  <= req.operand_a == '0;
			ctl_s1.a_neg   <= req.operand_a[31];
			ctl_s1.b_zero  <= req.operand_b == '0;
			ma_s1     <= abs_a[31:0];
			mb_s1     <= abs_b[31:0];
			simple_s1 <= simple;
		end
	end

	// Stage 2: magnitude product; from_int is a shift of operand_a.
	logic [63:0]        prod_s2;
	logic signed [63:0] wide_s2;
	ctl_t               ctl_s2;
	logic               v_s2;
	logic [NUM_W-1:0]   num_s2;
	logic [31:0]        den_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2  <= ctl_s1;
			prod_s2 <= 64'(ma_s1) * 64'(mb_s1);
			num_s2  <= NUM_W'(ma_s1) << FRAC_BITS;
			den_s2  <= mb_s1;
			if (ctl_s1.kind == OP_FROM_INT)
				wide_s2 <= 64'(simple_s1) + ((ctl_s1.a_neg ? -64'(ma_s1) : 64'(ma_s1))
					<<< FRAC_BITS);
			else
				wide_s2 <= 64'(simple_s1);
		end
	end

	// Stage 3: rounded product magnitude.
	logic [63:0]        pm_s3;
	logic signed [63:0] wide_s3;
	ctl_t               ctl_s3;
	logic               v_s3;
	logic [63:0]        half;
	assign half = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3  <= ctl_s2;
			pm_s3   <= (prod_s2 + half) >> FRAC_BITS;
			wide_s3 <= wide_s2;
		end
	end

	// Divider runs in parallel from stage 2; delay line for the rest.
	logic [NUM_W-1:0] quo;
	logic [32:0]      rem;
	fpa_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.num(num_s2), .den(den_s2), .quo(quo), .rem(rem)
	);

	localparam int DL = NUM_W - 1;
	ctl_t               ctl_d  [DL+1];
	logic [63:0]        pm_d   [DL+1];
	logic signed [63:0] wide_d [DL+1];
	logic [31:0]        den_d  [DL+2];
	logic               v_d    [DL+1];
	assign ctl_d[0]  = ctl_s3;
	assign pm_d[0]   = pm_s3;
	assign wide_d[0] = wide_s3;
	assign v_d[0]    = v_s3;
	assign den_d[0]  = den_s2;
	always_ff @(posedge clk) begin
		if (adv) den_d[1] <= den_d[0];
	end
	for (genvar i = 0; i < DL; i++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[i+1] <= 1'b0;
			else if (adv) v_d[i+1] <= v_d[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_d[i+1]  <= ctl_d[i];
				pm_d[i+1]   <= pm_d[i];
				wide_d[i+1] <= wide_d[i];
				den_d[i+2]  <= den_d[i+1];
			end
		end
	end

	// Final stage: rounding of the quotient, sign, saturation, output register.
	ctl_t               c;
	logic signed [63:0] mag, val;
	logic [32:0]        dmr;
	rsp_t               nxt;
	always_comb begin
		c   = ctl_d[DL];
		dmr = {1'b0, den_d[DL+1]} - rem;
		mag = '0;
		val = wide_d[DL];
		nxt = '0;
		nxt.less    = c.less;
		nxt.greater = c.greater;
		nxt.equal   = c.equal;
		if (c.kind == OP_MUL) begin
			mag = pm_d[DL];
			val = c.neg ? -mag : mag;
		end else if (c.kind == OP_DIV) begin
			mag = 64'(quo) + ((rem >= dmr) ? 64'd1 : 64'd0);
			val = c.neg ? -mag : mag;
		end
		if (c.kind == OP_DIV && c.b_zero) begin
			nxt.divide_by_zero = 1'b1;
			nxt.result = c.a_zero ? 32'sd0 : (c.a_neg ? WORD_MIN : WORD_MAX);
		end else if (c.kind inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INC, OP_DEC,
			OP_FROM_INT}) begin
			if (val > 64'sh7fff_ffff) begin
				nxt.result = WORD_MAX; nxt.overflow = 1'b1;
			end else if (val < -64'sh8000_0000) begin
				nxt.result = WORD_MIN; nxt.overflow = 1'b1;
			end else begin
				nxt.result = val[31:0];
			end
		end else begin
			nxt.result = val[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid <= 1'b0;
		else if (adv) rsp_valid <= v_d[DL];
	end
	always_ff @(posedge clk) begin
		if (adv) rsp <= nxt;
	end

	`include "fixed_point_alu_defines.svh"
	`FPA_ASSERT(a_stall_hold, clk, arst_n, (rsp_valid && !rsp_ready) |=> $stable(rsp))
	`FPA_ASSERT(a_ready, clk, arst_n, req_ready == (!rsp_valid || rsp_ready))
	`FPA_ASSERT(a_dz_div, clk, arst_n, (rsp_valid && rsp.divide_by_zero) |-> !rsp.overflow)
	`FPA_ASSERT(a_flags, clk, arst_n, rsp_valid |-> $onehot({rsp.less, rsp.greater, rsp.equal}))
	`FPA_ASSERT_RST(a_reset, clk, !arst_n |=> !rsp_valid)
endmodule

// ----- design/fpa_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, with stall.
module fpa_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W:0]   rem
);
	logic [NUM_W-1:0] q_s [NUM_W+1];
	logic [DEN_W:0]   r_s [NUM_W+1];
	logic [DEN_W-1:0] d_s [NUM_W+1];

	assign q_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W+1:0] sh;
		logic [DEN_W+1:0] diff;
		logic [NUM_W-1:0] qr;
		logic [DEN_W:0]   rr;
		logic [DEN_W-1:0] dr;
		assign sh   = {r_s[i], q_s[i][NUM_W-1]};
		assign diff = sh - {2'b00, d_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qr <= '0;
				rr <= '0;
				dr <= '0;
			end else if (adv) begin
				dr <= d_s[i];
				if (!diff[DEN_W+1]) begin
					rr <= diff[DEN_W:0];
					qr <= {q_s[i][NUM_W-2:0], 1'b1};
				end else begin
					rr <= sh[DEN_W:0];
					qr <= {q_s[i][NUM_W-2:0], 1'b0};
				end
			end
		end
		assign q_s[i+1] = qr;
		assign r_s[i+1] = rr;
		assign d_s[i+1] = dr;
	end

	assign quo = q_s[NUM_W];
	assign rem = r_s[NUM_W];
endmodule
